// File: src/c8ex_pkg.sv
// shared constants and types of the chip-8 execute core
package c8ex_pkg;

  // return stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int STK_DW      = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int INS_W  = 16;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 48;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic [ADDR_W-1:0] START_RESET = 12'h200;

  // result status
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_UNDERFLOW   = 2'd3
  } status_t;

  // instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SE_NN = 4'h3;
  localparam logic [3:0] GRP_SNE_NN= 4'h4;
  localparam logic [3:0] GRP_SE_V  = 4'h5;
  localparam logic [3:0] GRP_LD_NN = 4'h6;
  localparam logic [3:0] GRP_ADD_NN= 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNE_V = 4'h9;
  localparam logic [3:0] GRP_LD_I  = 4'hA;
  localparam logic [3:0] GRP_JP_V0 = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;

  // alu operations (low nibble of group 8)
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // full system instruction words
  localparam logic [INS_W-1:0] INS_CLS = 16'h00E0;
  localparam logic [INS_W-1:0] INS_RET = 16'h00EE;

  localparam logic [3:0] FLAG_REG = 4'hF;

endpackage

// File: src/chip8_instruction_execute_core.sv
// chip-8 instruction execute core: registers, return stack and execute logic
// datapath: an input transfer is captured in the input register, then executed
//   into the output register
// throughput: one instruction per cycle while the output is not stalled; the
//   register file read at input time with bypass of the instruction executing in the same cycle sets this
// reset (synchronous, rst_n low): pc to 0x200, start address to 0x200, v0-ve
//   read as zero via per-entry valid bits, vf, index and stack depth to 0
module chip8_instruction_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // instruction[15:0], random_byte[23:16]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // next_pc[11:0], index_value[23:12],
                                  // reg_write_valid[24], reg_write_num[28:25],
                                  // reg_write_value[36:29], flag_value[44:37],
                                  // clear_screen[45], status[47:46]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = c8ex_pkg::ADDR_W;
  localparam int BW = c8ex_pkg::BYTE_W;
  localparam int SD = c8ex_pkg::STACK_DEPTH;
  localparam int SA = c8ex_pkg::STK_AW;
  localparam int SW = c8ex_pkg::STK_DW;

  // ---------------------------------------------------------------------------
  // architectural state
  // ---------------------------------------------------------------------------
  logic [AW-1:0] start_r;
  logic [AW-1:0] pc_r;
  logic [AW-1:0] idx_r;
  logic [SW-1:0] depth_r;
  logic [AW-1:0] stack_r [SD];
  logic [BW-1:0] v0_r;       // shadow copy of v0 for the pc+v0 jump
  logic [BW-1:0] vf_r;       // flag register lives here, not in the file
  logic [BW-1:0] vmem [16];  // general register file, entry 15 unused
  logic [15:0]   vvld_r;     // entry written since reset

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic          in_valid_r;
  logic          out_valid_r;
  logic          in_fire;
  logic          ex_fire;

  // the execute stage moves whenever the output register is free or drains
  assign ex_fire   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || ex_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (ex_fire) begin
        in_valid_r <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input register and operand read
  // ---------------------------------------------------------------------------
  logic [15:0]   ins_r;
  logic [BW-1:0] rnd_r;
  logic [3:0]    in_x;
  logic [3:0]    in_y;
  logic [BW-1:0] rdx_raw_r, rdy_raw_r;
  logic          fwdx_sel_r, fwdy_sel_r;
  logic [BW-1:0] fwdx_val_r, fwdy_val_r;
  logic          fwdx_sel, fwdy_sel;
  logic [BW-1:0] fwdx_val, fwdy_val;

  // register file write port and next flag value of the executing item
  logic          wr_en;
  logic [3:0]    wr_addr;
  logic [BW-1:0] wr_data;
  logic [BW-1:0] vf_nxt;

  assign in_x = in_tdata[11:8];
  assign in_y = in_tdata[7:4];

  // bypass: flag register, a write in this same cycle, or a never-written entry
  always_comb begin
    fwdx_sel = 1'b1;
    fwdx_val = '0;
    if (in_x == c8ex_pkg::FLAG_REG) begin
      fwdx_val = vf_nxt;
    end else if (wr_en && wr_addr == in_x) begin
      fwdx_val = wr_data;
    end else if (!vvld_r[in_x]) begin
      fwdx_val = '0;
    end else begin
      fwdx_sel = 1'b0;
    end
    fwdy_sel = 1'b1;
    fwdy_val = '0;
    if (in_y == c8ex_pkg::FLAG_REG) begin
      fwdy_val = vf_nxt;
    end else if (wr_en && wr_addr == in_y) begin
      fwdy_val = wr_data;
    end else if (!vvld_r[in_y]) begin
      fwdy_val = '0;
    end else begin
      fwdy_sel = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rdx_raw_r <= vmem[in_x];
      rdy_raw_r <= vmem[in_y];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ins_r      <= in_tdata[15:0];
      rnd_r      <= in_tdata[23:16];
      fwdx_sel_r <= fwdx_sel;
      fwdx_val_r <= fwdx_val;
      fwdy_sel_r <= fwdy_sel;
      fwdy_val_r <= fwdy_val;
    end
  end

  // ---------------------------------------------------------------------------
  // execute
  // ---------------------------------------------------------------------------
  logic [3:0]        grp, ex_x, ex_n;
  logic [BW-1:0]     nn, vx, vy;
  logic [AW-1:0]     nnn;
  logic [AW-1:0]     pc_plus2, pc_plus4;
  logic [SW-1:0]     depth_m1;
  logic [AW-1:0]     stack_top;
  logic [BW:0]       sum9;
  logic [AW-1:0]     pc_nxt;
  c8ex_pkg::status_t st;
  logic [BW-1:0]     result, flag;
  logic              wx, wf, clr, push, pop, idx_wr;
  logic [BW-1:0]     vf_new;

  assign grp      = ins_r[15:12];
  assign ex_x     = ins_r[11:8];
  assign ex_n     = ins_r[3:0];
  assign nn       = ins_r[7:0];
  assign nnn      = ins_r[11:0];
  assign vx       = fwdx_sel_r ? fwdx_val_r : rdx_raw_r;
  assign vy       = fwdy_sel_r ? fwdy_val_r : rdy_raw_r;
  assign pc_plus2 = pc_r + AW'(2);
  assign pc_plus4 = pc_r + AW'(4);
  assign depth_m1 = depth_r - SW'(1);
  assign stack_top = stack_r[depth_m1[SA-1:0]];
  assign sum9     = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    pc_nxt = pc_plus2;
    st     = c8ex_pkg::ST_OK;
    result = '0;
    flag   = '0;
    wx     = 1'b0;
    wf     = 1'b0;
    clr    = 1'b0;
    push   = 1'b0;
    pop    = 1'b0;
    idx_wr = 1'b0;
    case (grp)
      c8ex_pkg::GRP_SYS: begin
        if (ins_r == c8ex_pkg::INS_CLS) begin
          clr = 1'b1;
        end else if (ins_r == c8ex_pkg::INS_RET) begin
          if (depth_r == '0) begin
            st = c8ex_pkg::ST_UNDERFLOW;
          end else begin
            pop    = 1'b1;
            pc_nxt = stack_top + AW'(2);
          end
        end else begin
          st = c8ex_pkg::ST_UNSUPPORTED;
        end
      end
      c8ex_pkg::GRP_JP: pc_nxt = nnn;
      c8ex_pkg::GRP_CALL: begin
        if (depth_r >= SW'(SD)) begin
          st = c8ex_pkg::ST_OVERFLOW;
        end else begin
          push   = 1'b1;
          pc_nxt = nnn;
        end
      end
      c8ex_pkg::GRP_SE_NN:  if (vx == nn) pc_nxt = pc_plus4;
      c8ex_pkg::GRP_SNE_NN: if (vx != nn) pc_nxt = pc_plus4;
      c8ex_pkg::GRP_SE_V:   if (vx == vy) pc_nxt = pc_plus4;
      c8ex_pkg::GRP_LD_NN: begin
        result = nn;
        wx     = 1'b1;
      end
      c8ex_pkg::GRP_ADD_NN: begin
        result = vx + nn;
        wx     = 1'b1;
      end
      c8ex_pkg::GRP_ALU: begin
        wx = 1'b1;
        case (ex_n)
          c8ex_pkg::ALU_MOV: result = vy;
          c8ex_pkg::ALU_OR:  result = vx | vy;
          c8ex_pkg::ALU_AND: result = vx & vy;
          c8ex_pkg::ALU_XOR: result = vx ^ vy;
          c8ex_pkg::ALU_ADD: begin
            result = sum9[BW-1:0];
            flag   = BW'(sum9[BW]);
            wf     = 1'b1;
          end
          c8ex_pkg::ALU_SUB: begin
            result = vx - vy;
            flag   = BW'(vx >= vy);
            wf     = 1'b1;
          end
          c8ex_pkg::ALU_SHR: begin
            result = vx >> 1;
            flag   = BW'(vx[0]);
            wf     = 1'b1;
          end
          c8ex_pkg::ALU_SBN: begin
            result = vy - vx;
            flag   = BW'(vy >= vx);
            wf     = 1'b1;
          end
          c8ex_pkg::ALU_SHL: begin
            result = vx << 1;
            flag   = BW'(vx[BW-1]);
            wf     = 1'b1;
          end
          default: begin
            wx = 1'b0;
            st = c8ex_pkg::ST_UNSUPPORTED;
          end
        endcase
      end
      c8ex_pkg::GRP_SNE_V: if (vx != vy) pc_nxt = pc_plus4;
      c8ex_pkg::GRP_LD_I:  idx_wr = 1'b1;
      c8ex_pkg::GRP_JP_V0: pc_nxt = nnn + AW'(v0_r);
      c8ex_pkg::GRP_RND: begin
        result = rnd_r & nn;
        wx     = 1'b1;
      end
      default: st = c8ex_pkg::ST_UNSUPPORTED;
    endcase
    // any error leaves the machine untouched
    if (st != c8ex_pkg::ST_OK) begin
      pc_nxt = pc_r;
      wx     = 1'b0;
      wf     = 1'b0;
      clr    = 1'b0;
      push   = 1'b0;
      pop    = 1'b0;
      idx_wr = 1'b0;
    end
  end

  // result write wins over the flag write when x is the flag register
  always_comb begin
    if (wx && ex_x == c8ex_pkg::FLAG_REG) begin
      vf_new = result;
    end else if (wf) begin
      vf_new = flag;
    end else begin
      vf_new = vf_r;
    end
  end

  assign vf_nxt  = ex_fire ? vf_new : vf_r;
  assign wr_en   = ex_fire && wx && (ex_x != c8ex_pkg::FLAG_REG);
  assign wr_addr = ex_x;
  assign wr_data = result;

  // ---------------------------------------------------------------------------
  // state update and configuration
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == c8ex_pkg::REG_START_ADDRESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= c8ex_pkg::START_RESET;
      pc_r    <= c8ex_pkg::START_RESET;
      idx_r   <= '0;
      depth_r <= '0;
      v0_r    <= '0;
      vf_r    <= '0;
      vvld_r  <= '0;
    end else begin
      if (ex_fire) begin
        pc_r <= pc_nxt;
        vf_r <= vf_new;
        if (idx_wr) begin
          idx_r <= nnn;
        end
        if (push) begin
          depth_r <= depth_r + SW'(1);
        end else if (pop) begin
          depth_r <= depth_m1;
        end
        if (wx && ex_x == 4'd0) begin
          v0_r <= result;
        end
      end
      if (wr_en) begin
        vvld_r[wr_addr] <= 1'b1;
      end
      // start address write also reloads the program counter
      if (cfg_wr) begin
        start_r <= cfg_pwdata[AW-1:0];
        pc_r    <= cfg_pwdata[AW-1:0];
      end
    end
  end

  // return stack entries: no reset, only entries below depth are read
  always_ff @(posedge clk) begin
    if (ex_fire && push) begin
      stack_r[depth_r[SA-1:0]] <= pc_r;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == c8ex_pkg::REG_START_ADDRESS) ?
                      {{(c8ex_pkg::CFG_DW-AW){1'b0}}, start_r} : '0;

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [AW-1:0]     o_pc_r, o_idx_r;
  logic              o_rwv_r, o_clr_r;
  logic [3:0]        o_num_r;
  logic [BW-1:0]     o_val_r, o_flag_r;
  c8ex_pkg::status_t o_st_r;

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      o_pc_r   <= pc_nxt;
      o_idx_r  <= idx_wr ? nnn : idx_r;
      o_rwv_r  <= wx;
      o_num_r  <= wx ? ex_x : 4'd0;
      o_val_r  <= wx ? result : '0;
      o_flag_r <= vf_new;
      o_clr_r  <= clr;
      o_st_r   <= st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_st_r, o_clr_r, o_flag_r, o_val_r, o_num_r, o_rwv_r,
                       o_idx_r, o_pc_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_err_no_side_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (o_st_r != c8ex_pkg::ST_OK) |-> !o_rwv_r && !o_clr_r)
    else $error("error result reports a register write or clear");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SW'(SD))
    else $error("stack depth beyond capacity");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && push |=> depth_r == SW'($past(depth_r) + SW'(1)))
    else $error("call did not grow the stack");

  a_err_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && (st != c8ex_pkg::ST_OK) && !cfg_wr |=> $stable(pc_r))
    else $error("program counter moved on an error");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule
